### rtl/tcbe_pkg.sv
// ----------------------------------------------------------------------------
// tcbe_pkg
// Shared types and constants for the track channel bit extractor.
// ----------------------------------------------------------------------------
package tcbe_pkg;

  // default sizing of the block
  localparam int DEF_MAX_CHANNELS    = 8;
  localparam int DEF_TRACK_WORD_BITS = 64;
  localparam int DEF_MAX_FAN_OUT     = 4;

  // fixed field widths
  localparam int WORD_MAX_BITS  = 64;
  localparam int TRACK_POS_W    = 6;
  localparam int SEL_W          = 48;
  localparam int SEL_REGS       = 4;
  localparam int CFG_INDEX_W    = 3;
  localparam int CHAN_FIELD_W   = 3;
  localparam int COUNT_W        = 4;
  localparam int FAN_CODE_W     = 2;
  localparam int FAN_W          = 3;
  localparam int BYTE_W         = 8;
  localparam int SLOTS_PER_CHAN = 4;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FAN_OUT_LOG2  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACK_SEL_A   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACK_SEL_B   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACK_SEL_C   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACK_SEL_D   = 3'd5;

  // effective settings handed to the packer
  typedef struct packed {
    logic [COUNT_W-1:0] active;   // active channels, 1..MAX_CHANNELS
    logic [FAN_W-1:0]   fan_out;  // bits per channel per word: 1, 2 or 4
  } cfg_t;

  // burst load request from packer to output stage
  typedef struct packed {
    logic                    load;
    logic [CHAN_FIELD_W-1:0] last_idx;
  } burst_load_t;

endpackage

### rtl/track_channel_bit_extractor.sv
// ----------------------------------------------------------------------------
// track_channel_bit_extractor
// Pulls channel sample bits out of multi-track recorder words and packs
// them into per-channel bytes.
// ----------------------------------------------------------------------------
// Each accepted word is held in the input register, so words that do
// not complete a byte go through at one per cycle. A word that
// completes the bytes loads the output bank, which sends one result per
// cycle unless out_stall is high; a further completing word waits in the
// input register until the last byte of the current set is taken, and
// the block pauses on output stalls. At fan-out four that is one result
// per active channel every two words. Configuration is to be written by
// the user only while the block is idle; the block does not enforce it.
module track_channel_bit_extractor import tcbe_pkg::*; #(
  parameter int MAX_CHANNELS    = DEF_MAX_CHANNELS,
  parameter int TRACK_WORD_BITS = DEF_TRACK_WORD_BITS,
  parameter int MAX_FAN_OUT     = DEF_MAX_FAN_OUT
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [SEL_W-1:0]           cfg_data,
  // input words
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [TRACK_WORD_BITS-1:0] track_bits,
  input  logic                       frame_start,
  // channel bytes
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [CHAN_FIELD_W-1:0]    channel_index,
  output logic [BYTE_W-1:0]          packed_byte,
  output logic                       last_of_run
);

  cfg_t              cfg;
  logic [SEL_W-1:0]  track_sel [SEL_REGS];
  burst_load_t       ld;
  logic [BYTE_W-1:0] done_bytes [MAX_CHANNELS];
  logic              burst_free;

  tcbe_cfg #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FAN_OUT  (MAX_FAN_OUT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .track_sel (track_sel)
  );

  tcbe_packer #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .TRACK_WORD_BITS (TRACK_WORD_BITS),
    .MAX_FAN_OUT     (MAX_FAN_OUT)
  ) u_packer (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .track_bits  (track_bits),
    .frame_start (frame_start),
    .cfg         (cfg),
    .track_sel   (track_sel),
    .burst_free  (burst_free),
    .ld          (ld),
    .done_bytes  (done_bytes)
  );

  tcbe_burst #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_burst (
    .clk           (clk),
    .rst           (rst),
    .ld            (ld),
    .done_bytes    (done_bytes),
    .burst_free    (burst_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .packed_byte   (packed_byte),
    .last_of_run   (last_of_run)
  );

endmodule

### rtl/tcbe_cfg.sv
// ----------------------------------------------------------------------------
// tcbe_cfg
// Configuration registers and their saturation to effective settings.
// ----------------------------------------------------------------------------
module tcbe_cfg import tcbe_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_FAN_OUT  = DEF_MAX_FAN_OUT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SEL_W-1:0]       cfg_data,
  output cfg_t                   cfg,
  output logic [SEL_W-1:0]       track_sel [SEL_REGS]
);

  // largest supported fan-out code
  localparam int FAN_CODE_MAX = (MAX_FAN_OUT >= 4) ? 2 : ((MAX_FAN_OUT >= 2) ? 1 : 0);
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_CHANNELS);

  logic [COUNT_W-1:0]    channel_count;
  logic [FAN_CODE_W-1:0] fan_out_log2;
  logic                  wr;
  logic [FAN_CODE_W-1:0] code_sat;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= COUNT_W'(1);
      fan_out_log2  <= '0;
      for (int r = 0; r < SEL_REGS; r++) begin
        track_sel[r] <= '0;
      end
    end else if (wr) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[COUNT_W-1:0];
        REG_FAN_OUT_LOG2:  fan_out_log2  <= cfg_data[FAN_CODE_W-1:0];
        REG_TRACK_SEL_A:   track_sel[0]  <= cfg_data;
        REG_TRACK_SEL_B:   track_sel[1]  <= cfg_data;
        REG_TRACK_SEL_C:   track_sel[2]  <= cfg_data;
        REG_TRACK_SEL_D:   track_sel[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // active channel count: zero means one, saturate at the channel limit
    if (channel_count == '0) begin
      cfg.active = COUNT_W'(1);
    end else if (channel_count > MAX_COUNT) begin
      cfg.active = MAX_COUNT;
    end else begin
      cfg.active = channel_count;
    end

    // fan-out code saturated to four bits and to the fan-out limit
    code_sat = fan_out_log2;
    if (code_sat > FAN_CODE_W'(FAN_CODE_MAX)) begin
      code_sat = FAN_CODE_W'(FAN_CODE_MAX);
    end
    cfg.fan_out = FAN_W'(1) << code_sat;
  end

endmodule

### rtl/tcbe_packer.sv
// ----------------------------------------------------------------------------
// tcbe_packer
// Input register, per-channel partial bytes and bit position. Hands a
// completed set of bytes to the output stage.
// ----------------------------------------------------------------------------
module tcbe_packer import tcbe_pkg::*; #(
  parameter int MAX_CHANNELS    = DEF_MAX_CHANNELS,
  parameter int TRACK_WORD_BITS = DEF_TRACK_WORD_BITS,
  parameter int MAX_FAN_OUT     = DEF_MAX_FAN_OUT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [TRACK_WORD_BITS-1:0] track_bits,
  input  logic                       frame_start,
  input  cfg_t                       cfg,
  input  logic [SEL_W-1:0]           track_sel [SEL_REGS],
  input  logic                       burst_free,
  output burst_load_t                ld,
  output logic [BYTE_W-1:0]          done_bytes [MAX_CHANNELS]
);

  // input register
  logic                       in_full;
  logic [TRACK_WORD_BITS-1:0] word_q;
  logic                       fs_q;

  // packing state
  logic [2:0]        bit_position;
  logic [BYTE_W-1:0] partial_byte [MAX_CHANNELS];

  logic [WORD_MAX_BITS-1:0] word_ext;
  logic [2:0]               base;
  logic [3:0]               total;
  logic                     complete;
  logic                     advance;
  logic                     accept;
  logic [BYTE_W-1:0]        new_byte [MAX_CHANNELS];

  assign complete = total[3];
  assign advance  = in_full && (!complete || burst_free);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_q <= track_bits;
      fs_q   <= frame_start;
    end
  end

  // gather fan-out bits for every active channel
  always_comb begin
    logic [SEL_W-1:0]       sel;
    logic [TRACK_POS_W-1:0] pos;
    logic [3:0]             shamt;
    pos      = '0;
    shamt    = '0;
    word_ext = WORD_MAX_BITS'(word_q);
    base     = fs_q ? 3'd0 : bit_position;
    total    = {1'b0, base} + {1'b0, cfg.fan_out};
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      new_byte[c] = fs_q ? '0 : partial_byte[c];
      sel = track_sel[c >> 1];
      if (COUNT_W'(c) < cfg.active) begin
        for (int k = 0; k < MAX_FAN_OUT; k++) begin
          pos   = sel[TRACK_POS_W * ((c & 1) * SLOTS_PER_CHAN + k) +: TRACK_POS_W];
          shamt = {1'b0, base} + 4'(k);
          if (FAN_W'(k) < cfg.fan_out) begin
            new_byte[c] = new_byte[c] | (BYTE_W'(word_ext[pos]) << shamt);
          end
        end
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        partial_byte[c] <= '0;
      end
    end else if (advance) begin
      bit_position <= complete ? 3'd0 : total[2:0];
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        partial_byte[c] <= complete ? '0 : new_byte[c];
      end
    end
  end

  // completed bytes to the output stage
  assign ld.load     = advance && complete;
  assign ld.last_idx = CHAN_FIELD_W'(cfg.active - COUNT_W'(1));
  assign done_bytes  = new_byte;

endmodule

### rtl/tcbe_burst.sv
// ----------------------------------------------------------------------------
// tcbe_burst
// Holds one set of completed channel bytes and sends them out one per
// transfer, in channel order, marking the last one.
// ----------------------------------------------------------------------------
module tcbe_burst import tcbe_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  burst_load_t             ld,
  input  logic [BYTE_W-1:0]       done_bytes [MAX_CHANNELS],
  output logic                    burst_free,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CHAN_FIELD_W-1:0] channel_index,
  output logic [BYTE_W-1:0]       packed_byte,
  output logic                    last_of_run
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic              active;
  logic [CH_W-1:0]   idx;
  logic [CH_W-1:0]   last_q;
  logic [BYTE_W-1:0] bytes [MAX_CHANNELS];
  logic              at_last;
  logic              take;

  assign at_last    = (idx == last_q);
  assign take       = active && !out_stall;
  assign burst_free = !active || (take && at_last);

  // burst control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (ld.load) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (take) begin
      if (at_last) begin
        active <= 1'b0;
      end else begin
        idx <= idx + CH_W'(1);
      end
    end
  end

  // byte bank
  always_ff @(posedge clk) begin
    if (ld.load) begin
      bytes  <= done_bytes;
      last_q <= CH_W'(ld.last_idx);
    end
  end

  assign out_valid     = active;
  assign channel_index = CHAN_FIELD_W'(idx);
  assign packed_byte   = bytes[idx];
  assign last_of_run   = at_last;

endmodule
